/* hdl/ksl_pkg.sv */
`timescale 1ns / 1ps

package ksl_pkg;

  localparam int unsigned TickDivideReset = 20;
  localparam int unsigned LongPressMs     = 3000;
  localparam int unsigned LongPressReset  =
    (LongPressMs + TickDivideReset - 1) / TickDivideReset;

  localparam logic [7:0]  TICK_DIVIDE_RST = 8'(TickDivideReset);
  localparam logic [15:0] LONG_PRESS_RST  = 16'(LongPressReset);

  localparam int unsigned CfgDataWidth = 16;

  typedef enum logic {
    CFG_TICK_DIVIDE = 1'b0,
    CFG_LONG_PRESS  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_e;

  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_1    = 2'd1;
  localparam logic [1:0] KEY_2    = 2'd2;
  localparam logic [1:0] KEY_3    = 2'd3;

  typedef struct packed {
    logic       command;
    logic [2:0] key_levels;
    logic       guard_active;
  } item_t;

  typedef struct packed {
    logic [1:0] key_number;
    logic       sleep_request;
    logic       clear_guard;
    logic       reset_idle_timer;
  } result_t;

  typedef struct packed {
    logic [7:0]  tick_count;
    logic [1:0]  current_code;
    logic [1:0]  previous_code;
    logic [15:0] hold_count;
    logic        long_press_done;
    logic [1:0]  pending_key;
  } state_t;

  typedef struct packed {
    logic [7:0]  tick_divide;
    logic [15:0] long_press_scans;
  } cfg_t;

  function automatic logic [1:0] encode_keys(input logic [2:0] levels);
    logic [1:0] code;
    code = KEY_NONE;
    priority if (levels[0]) code = KEY_1;
    else if (levels[1]) code = KEY_2;
    else if (levels[2]) code = KEY_3;
    else code = KEY_NONE;
    return code;
  endfunction

endpackage

/* hdl/ksl_scan.sv */
`timescale 1ns / 1ps

module ksl_scan import ksl_pkg::*; (
  input  item_t   item_i,
  input  state_t  state_i,
  input  cfg_t    cfg_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [7:0]  tick_inc;
  logic [1:0]  code_new;
  logic [15:0] hold_new;

  assign tick_inc = state_i.tick_count + 8'd1;
  assign code_new = encode_keys(item_i.key_levels);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    hold_new = state_i.hold_count;
    if (item_i.command == CMD_FETCH) begin
      result_o.key_number = state_i.pending_key;
      state_o.pending_key = KEY_NONE;
    end else if (tick_inc < cfg_i.tick_divide) begin
      state_o.tick_count = tick_inc;
    end else begin
      state_o.tick_count    = '0;
      state_o.previous_code = state_i.current_code;
      state_o.current_code  = code_new;
      if (item_i.guard_active) begin
        if (code_new != KEY_3) begin
          result_o.clear_guard      = 1'b1;
          result_o.reset_idle_timer = (state_i.current_code == KEY_3);
        end
        state_o.hold_count      = '0;
        state_o.long_press_done = 1'b0;
      end else begin
        if (code_new == KEY_3) begin
          if (state_i.hold_count < cfg_i.long_press_scans) begin
            hold_new = state_i.hold_count + 16'd1;
          end
          state_o.hold_count = hold_new;
          if (!state_i.long_press_done && hold_new >= cfg_i.long_press_scans) begin
            state_o.long_press_done = 1'b1;
            result_o.sleep_request  = 1'b1;
          end
        end else begin
          state_o.hold_count = '0;
        end
        // release of all keys
        if (code_new == KEY_NONE && state_i.current_code != KEY_NONE) begin
          if (!(state_i.current_code == KEY_3 && state_i.long_press_done)) begin
            state_o.pending_key = state_i.current_code;
          end
          state_o.long_press_done   = 1'b0;
          result_o.reset_idle_timer = 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/key_scan_long_press_core.sv */
`timescale 1ns / 1ps
// data path: a word is registered on input and its result is registered into the result
// register when the output is free; an output stall holds it in the input stage
// throughput: one word per cycle unless stalled; input stage and result register form a
// two-stage pipeline whose scan state updates when a word moves into the result register
// reset: valid flags, scan state and configuration registers return to their defaults
// (tick divide 20, long press 150 scans); no words are held after reset

module key_scan_long_press_core import ksl_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    in_vld_i,
  output logic                    in_stall_o,
  input  logic                    command_i,
  input  logic [2:0]              key_levels_i,
  input  logic                    guard_active_i,
  output logic                    out_vld_o,
  input  logic                    out_stall_i,
  output logic [1:0]              key_number_o,
  output logic                    sleep_request_o,
  output logic                    clear_guard_o,
  output logic                    reset_idle_timer_o
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item_q;
  logic    in_vld_q;
  result_t res_q, res_d;
  logic    out_vld_q;
  logic    out_free;
  logic    advance;
  logic    in_take;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_vld_i && !in_stall_o;

  ksl_scan u_scan (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_divide      <= TICK_DIVIDE_RST;
      cfg_q.long_press_scans <= LONG_PRESS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TICK_DIVIDE: cfg_q.tick_divide      <= cfg_data_i[7:0];
        CFG_LONG_PRESS:  cfg_q.long_press_scans <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.command      <= command_i;
      item_q.key_levels   <= key_levels_i;
      item_q.guard_active <= guard_active_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_vld_o          = out_vld_q;
  assign key_number_o       = res_q.key_number;
  assign sleep_request_o    = res_q.sleep_request;
  assign clear_guard_o      = res_q.clear_guard;
  assign reset_idle_timer_o = res_q.reset_idle_timer;

`ifndef NO_ASSERTIONS
  a_fetch_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_o && key_number_o != KEY_NONE |->
      !sleep_request_o && !clear_guard_o && !reset_idle_timer_o)
    else $error("fetch word carries a pulse");

  a_sleep_not_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_o |-> !(sleep_request_o && clear_guard_o))
    else $error("sleep request and guard clear together");

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !in_stall_o)
    else $error("input stalled with empty stage");

  a_state_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("scan state changed without a word");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ksl_pkg::*;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic                    cfg_idx_i = CFG_TICK_DIVIDE;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;
  logic                    in_vld_i = 1'b0;
  logic                    in_stall_o;
  logic                    command_i = CMD_TICK;
  logic [2:0]              key_levels_i = 3'b000;
  logic                    guard_active_i = 1'b0;
  logic                    out_vld_o;
  logic                    out_stall_i = 1'b0;
  logic [1:0]              key_number_o;
  logic                    sleep_request_o;
  logic                    clear_guard_o;
  logic                    reset_idle_timer_o;

  key_scan_long_press_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_vld_i           (in_vld_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .key_levels_i       (key_levels_i),
    .guard_active_i     (guard_active_i),
    .out_vld_o          (out_vld_o),
    .out_stall_i        (out_stall_i),
    .key_number_o       (key_number_o),
    .sleep_request_o    (sleep_request_o),
    .clear_guard_o      (clear_guard_o),
    .reset_idle_timer_o (reset_idle_timer_o)
  );

  always #10 clk_i = ~clk_i;

  item_t   key_word_q[$];
  result_t report_q[$];
  int      err_cnt = 0;

  // scanner copy
  logic [7:0]  tick_div = TICK_DIVIDE_RST;
  logic [15:0] press_limit = LONG_PRESS_RST;
  logic [7:0]  tick_cnt = '0;
  logic [1:0]  cur_code = KEY_NONE;
  logic [1:0]  prev_code = KEY_NONE;
  logic [15:0] hold_cnt = '0;
  logic        press_fired = 1'b0;
  logic [1:0]  pend_key = KEY_NONE;

  function automatic result_t predict_report(item_t it);
    result_t r;
    r = '0;
    if (it.command == CMD_FETCH) begin
      r.key_number = pend_key;
      pend_key = KEY_NONE;
    end else begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= tick_div) begin
        tick_cnt = '0;
        prev_code = cur_code;
        casez (it.key_levels)
          3'b??1: cur_code = KEY_1;
          3'b?10: cur_code = KEY_2;
          3'b100: cur_code = KEY_3;
          default: cur_code = KEY_NONE;
        endcase
        if (it.guard_active) begin
          if (cur_code != KEY_3) begin
            r.clear_guard = 1'b1;
            if (prev_code == KEY_3) r.reset_idle_timer = 1'b1;
          end
          hold_cnt = '0;
          press_fired = 1'b0;
        end else begin
          if (cur_code == KEY_3) begin
            if (hold_cnt < press_limit) hold_cnt = hold_cnt + 16'd1;
            if (!press_fired && hold_cnt >= press_limit) begin
              press_fired = 1'b1;
              r.sleep_request = 1'b1;
            end
          end else begin
            hold_cnt = '0;
          end
          if (cur_code == KEY_NONE && prev_code != KEY_NONE) begin
            if (!(prev_code == KEY_3 && press_fired)) pend_key = prev_code;
            press_fired = 1'b0;
            r.reset_idle_timer = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // sender: bursts of words with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i) begin : drv_proc
    logic  nxt_vld;
    item_t nxt;
    if (rst_ni) begin
      nxt_vld = in_vld_i;
      nxt = item_t'({command_i, key_levels_i, guard_active_i});
      if (in_vld_i && !in_stall_o) begin
        report_q.push_back(predict_report(nxt));
        nxt_vld = 1'b0;
      end
      if (!nxt_vld) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (key_word_q.size() > 0) begin
          nxt = key_word_q.pop_front();
          nxt_vld = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_vld_i <= nxt_vld;
      command_i <= nxt.command;
      key_levels_i <= nxt.key_levels;
      guard_active_i <= nxt.guard_active;
    end
  end

  // receiver: stall pattern switching between modes
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk_i) begin : mon_proc
    result_t want;
    logic    nxt_stall;
    if (rst_ni) begin
      if (out_vld_o && !out_stall_i) begin
        if (report_q.size() == 0) begin
          $error("unexpected word: key_number %0d sleep_request %0b clear_guard %0b %s %0b",
                 key_number_o, sleep_request_o, clear_guard_o, "reset_idle_timer",
                 reset_idle_timer_o);
          err_cnt++;
        end else begin
          want = report_q.pop_front();
          if (key_number_o !== want.key_number) begin
            $error("key_number expected %0d got %0d", want.key_number, key_number_o);
            err_cnt++;
          end
          if (sleep_request_o !== want.sleep_request) begin
            $error("sleep_request expected %0b got %0b", want.sleep_request, sleep_request_o);
            err_cnt++;
          end
          if (clear_guard_o !== want.clear_guard) begin
            $error("clear_guard expected %0b got %0b", want.clear_guard, clear_guard_o);
            err_cnt++;
          end
          if (reset_idle_timer_o !== want.reset_idle_timer) begin
            $error("reset_idle_timer expected %0b got %0b", want.reset_idle_timer,
                   reset_idle_timer_o);
            err_cnt++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(32, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: nxt_stall = 1'b0;
        1: nxt_stall = ($urandom_range(0, 3) == 0);
        default: nxt_stall = ($urandom_range(0, 7) < 6);
      endcase
      out_stall_i <= nxt_stall;
    end
  end

  task automatic wait_idle();
    int n;
    n = 0;
    do begin
      @(negedge clk_i);
      n++;
    end while (n < 100000 && !(key_word_q.size() == 0 && !in_vld_i && report_q.size() == 0));
    repeat (4) @(negedge clk_i);
    if (report_q.size() != 0) begin
      $error("%0d expected words never arrived", report_q.size());
      err_cnt++;
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataWidth-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TICK_DIVIDE) tick_div = val[7:0];
    else press_limit = val;
  endtask

  task automatic set_scan(logic [7:0] div, logic [15:0] limit);
    wait_idle();
    write_reg(CFG_TICK_DIVIDE, {8'($urandom_range(0, 255)), div});
    write_reg(CFG_LONG_PRESS, limit);
    @(negedge clk_i);
  endtask

  task automatic push_word(cmd_e cmd, logic [2:0] lv, logic grd);
    key_word_q.push_back(item_t'({cmd, lv, grd}));
  endtask

  // mostly press/hold/release sequences, some noise
  task automatic gen_words(int n);
    int         cnt;
    int         eff_div;
    int         hold;
    int         rel;
    int         hold_max;
    logic [2:0] lv;
    logic       grd;
    cnt = 0;
    eff_div = (tick_div == 0) ? 1 : tick_div;
    hold_max = eff_div * (press_limit + 2) + 1;
    if (hold_max > 60) hold_max = 60;
    while (cnt < n) begin
      if ($urandom_range(0, 9) == 0) begin
        key_word_q.push_back(item_t'(5'($urandom_range(0, 31))));
        cnt++;
      end else begin
        case ($urandom_range(0, 5))
          0: lv = 3'b001;
          1: lv = 3'b010;
          2, 3: lv = 3'b100;
          default: lv = 3'($urandom_range(1, 7));
        endcase
        grd = ($urandom_range(0, 5) == 0);
        hold = $urandom_range(1, hold_max);
        rel = $urandom_range(1, (2 * eff_div + 1 > 20) ? 20 : 2 * eff_div + 1);
        repeat (hold) begin
          if ($urandom_range(0, 19) == 0) lv = 3'($urandom_range(1, 7));
          push_word(CMD_TICK, lv, grd ^ ($urandom_range(0, 15) == 0));
        end
        repeat (rel) push_word(CMD_TICK, 3'b000, grd ^ ($urandom_range(0, 15) == 0));
        cnt += hold + rel;
        if ($urandom_range(0, 2) == 0) begin
          push_word(CMD_FETCH, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
          cnt++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    gen_words(100);

    // scan every tick, long press after two scans
    set_scan(8'd1, 16'd2);
    push_word(CMD_TICK, 3'b001, 1'b0);
    push_word(CMD_TICK, 3'b000, 1'b0);
    push_word(CMD_FETCH, 3'b000, 1'b0);
    push_word(CMD_FETCH, 3'b111, 1'b1);
    push_word(CMD_TICK, 3'b111, 1'b0);
    push_word(CMD_TICK, 3'b110, 1'b0);
    push_word(CMD_TICK, 3'b000, 1'b0);
    push_word(CMD_FETCH, 3'b000, 1'b0);
    // long press, then release latches nothing
    push_word(CMD_TICK, 3'b100, 1'b0);
    push_word(CMD_TICK, 3'b100, 1'b0);
    push_word(CMD_TICK, 3'b100, 1'b0);
    push_word(CMD_TICK, 3'b000, 1'b0);
    push_word(CMD_FETCH, 3'b000, 1'b0);
    // long press then moved to key2
    push_word(CMD_TICK, 3'b100, 1'b0);
    push_word(CMD_TICK, 3'b100, 1'b0);
    push_word(CMD_TICK, 3'b010, 1'b0);
    push_word(CMD_TICK, 3'b000, 1'b0);
    push_word(CMD_FETCH, 3'b000, 1'b0);
    // guard handling
    push_word(CMD_TICK, 3'b100, 1'b1);
    push_word(CMD_TICK, 3'b000, 1'b1);
    push_word(CMD_TICK, 3'b001, 1'b1);
    push_word(CMD_TICK, 3'b000, 1'b0);
    push_word(CMD_FETCH, 3'b111, 1'b1);
    gen_words(250);

    // zero divide and zero threshold
    set_scan(8'd0, 16'd0);
    push_word(CMD_TICK, 3'b100, 1'b0);
    push_word(CMD_TICK, 3'b000, 1'b0);
    gen_words(150);

    set_scan(8'd3, 16'd5);
    gen_words(250);

    set_scan(8'd255, 16'd1);
    gen_words(280);

    set_scan(8'd1, 16'd65535);
    gen_words(120);

    set_scan(8'd2, 16'd3);
    gen_words(200);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

/* files.f */
hdl/ksl_pkg.sv
hdl/ksl_scan.sv
hdl/key_scan_long_press_core.sv
tb/sv/testbench.sv
